### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on clk and disabled while rst_n is
// low. Synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(name, ante, cons, msg)
`define ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

### rtl/wica_pkg.sv
// ----------------------------------------------------------------------------
// wica_pkg
// Widths, constants and shared types of the weighted interval cell average.
// ----------------------------------------------------------------------------
package wica_pkg;

  // Field widths.
  localparam int COORD_BITS  = 24;
  localparam int VALUE_W     = 16;
  localparam int WEIGHT_W    = 12;
  localparam int AVG_W       = 16;

  // Arithmetic widths.
  localparam int OV_W        = COORD_BITS + 1;
  localparam int WPROD_W     = OV_W + WEIGHT_W;
  localparam int VPROD_W     = WPROD_W + VALUE_W;
  localparam int VSUM_W      = 62;
  localparam int WSUM_W      = 46;
  localparam int VADD_W      = VSUM_W + 1;
  localparam int WADD_W      = WSUM_W + 1;

  // Divider: 17 quotient bits plus one that flags a quotient of 2^17 or more.
  localparam int QUOT_W      = AVG_W + 2;
  localparam int STEP_W      = $clog2(QUOT_W);
  localparam int DEN_W       = WSUM_W + QUOT_W - 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_CELLS_DEF = 1024;

  localparam logic signed [VSUM_W-1:0] VSUM_MAX = {1'b0, {(VSUM_W-1){1'b1}}};
  localparam logic signed [VSUM_W-1:0] VSUM_MIN = {1'b1, {(VSUM_W-1){1'b0}}};
  localparam logic [WSUM_W-1:0]        WSUM_MAX = {WSUM_W{1'b1}};

  // Operation carried from the front to the back.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CELL  = 2'd1,
    OP_DROP  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t                    kind;
    logic                        last;
    logic [OV_W-1:0]             overlap;
    logic [WEIGHT_W-1:0]         weight;
    logic signed [VALUE_W-1:0]   value;
  } op_t;

  // Final sums handed from the accumulator to the divider.
  typedef struct packed {
    logic                        valid;
    logic                        flag;
    logic signed [VSUM_W-1:0]    vsum;
    logic [WSUM_W-1:0]           wsum;
  } div_req_t;

endpackage

### rtl/wica_in_if.sv
// ----------------------------------------------------------------------------
// wica_in_if
// Input channel: query start and grid cell beats.
// ----------------------------------------------------------------------------
interface wica_in_if;
  import wica_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [COORD_BITS-1:0] query_low;
  logic signed [COORD_BITS-1:0] query_high;
  logic signed [COORD_BITS-1:0] face_left;
  logic signed [COORD_BITS-1:0] face_right;
  logic signed [VALUE_W-1:0]    cell_value;
  logic [WEIGHT_W-1:0]          cell_weight;
  logic                         last_cell;

  modport source (
    output valid, kind, query_low, query_high, face_left, face_right,
    output cell_value, cell_weight, last_cell,
    input  ready
  );

  modport sink (
    input  valid, kind, query_low, query_high, face_left, face_right,
    input  cell_value, cell_weight, last_cell,
    output ready
  );
endinterface

### rtl/wica_out_if.sv
// ----------------------------------------------------------------------------
// wica_out_if
// Result channel: one weighted average beat per last cell.
// ----------------------------------------------------------------------------
interface wica_out_if;
  import wica_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [AVG_W-1:0]   average;
  logic                      zero_weight;
  logic                      saturated;

  modport source (
    output valid, average, zero_weight, saturated,
    input  ready
  );

  modport sink (
    input  valid, average, zero_weight, saturated,
    output ready
  );
endinterface

### rtl/weighted_interval_cell_average.sv
// Path: a last cell beat, once taken, passes through two multiply stages (the
//   first loads straight from the queue), the accumulate stage, divider set-up,
//   18 divider steps (one quotient bit each) and the output register.
// Throughput: one cell beat per cycle inside a query while the queue has room;
//   after its last cell the back end holds further work until the divider has finished that query.
// Reset: synchronous, active low; clears interval, sums, count and all valids.
// ----------------------------------------------------------------------------
// weighted_interval_cell_average
// Weighted average of cell values over an interval on a non-uniform grid:
// front end with cell clipping, operation queue, multiply-accumulate back end
// and a bit-serial divider.
// ----------------------------------------------------------------------------
module weighted_interval_cell_average #(
  parameter int MAX_CELLS = wica_pkg::MAX_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  wica_in_if.sink     in_ch,
  wica_out_if.source  out_ch
);
  import wica_pkg::*;

  logic     push;
  op_t      push_op;
  logic     q_full;
  logic     pop;
  op_t      head;
  logic     q_empty;
  logic     div_busy;
  div_req_t div_req;

  // Accept and classify beats.
  wica_front #(
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .push    (push),
    .push_op (push_op),
    .q_full  (q_full)
  );

  // Operation queue.
  wica_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty)
  );

  // Multiply and accumulate.
  wica_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .div_busy (div_busy),
    .div_req  (div_req)
  );

  // Final division and result register.
  wica_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .busy    (div_busy),
    .out_ch  (out_ch)
  );

endmodule

### rtl/wica_front.sv
// ----------------------------------------------------------------------------
// wica_front
// Accepts beats, holds the interval and the cell count, clips each cell to
// the interval and queues one operation per beat.
// ----------------------------------------------------------------------------
module wica_front #(
  parameter int MAX_CELLS = wica_pkg::MAX_CELLS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  wica_in_if.sink        in_ch,
  output logic           push,
  output wica_pkg::op_t  push_op,
  input  logic           q_full
);
  import wica_pkg::*;

  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  logic signed [COORD_BITS-1:0] ilow_r, ilow_nxt;
  logic signed [COORD_BITS-1:0] ihigh_r, ihigh_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;

  logic                         accept;
  logic                         cells_full;
  logic signed [COORD_BITS-1:0] lo;
  logic signed [COORD_BITS-1:0] hi;
  logic signed [OV_W-1:0]       diff;

  // A beat is taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign push        = accept;
  assign cells_full  = (cnt_r >= CNT_W'(MAX_CELLS));

  // Clip the cell faces to the interval; an empty overlap counts as zero.
  always_comb begin
    lo   = (in_ch.face_left < ilow_r) ? ilow_r : in_ch.face_left;
    hi   = (in_ch.face_right > ihigh_r) ? ihigh_r : in_ch.face_right;
    diff = OV_W'(hi) - OV_W'(lo);
  end

  // Build the queued operation.
  always_comb begin
    push_op.kind    = !in_ch.kind ? OP_START : (cells_full ? OP_DROP : OP_CELL);
    push_op.last    = in_ch.kind && in_ch.last_cell;
    push_op.overlap = (hi > lo) ? OV_W'(diff) : '0;
    push_op.weight  = in_ch.cell_weight;
    push_op.value   = in_ch.cell_value;
  end

  // Interval and cell count.
  always_comb begin
    ilow_nxt  = ilow_r;
    ihigh_nxt = ihigh_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      if (!in_ch.kind) begin
        ilow_nxt  = in_ch.query_low;
        ihigh_nxt = in_ch.query_high;
        cnt_nxt   = '0;
      end else if (in_ch.last_cell) begin
        cnt_nxt = '0;
      end else if (!cells_full) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ilow_r  <= '0;
      ihigh_r <= '0;
      cnt_r   <= '0;
    end else begin
      ilow_r  <= ilow_nxt;
      ihigh_r <= ihigh_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/wica_queue.sv
// ----------------------------------------------------------------------------
// wica_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wica_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wica_pkg::op_t  push_op,
  output logic           full,
  input  logic           pop,
  output wica_pkg::op_t  head,
  output logic           empty
);
  import wica_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  `ASSERT_IMP(a_no_push_full, full, !push, "queue written while full")
  `ASSERT_IMP(a_no_pop_empty, empty, !pop, "queue read while empty")
  `ASSERT_NXT(a_fill_up, push && !pop, count_r == $past(count_r) + 1'b1,
              "queue fill level did not grow on a lone write")

endmodule

### rtl/wica_back.sv
// ----------------------------------------------------------------------------
// wica_back
// Two-stage multiply pipeline and saturating accumulators; hands the final
// sums of each query to the divider.
// ----------------------------------------------------------------------------
module wica_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  wica_pkg::op_t      head,
  output logic               pop,
  input  logic               div_busy,
  output wica_pkg::div_req_t div_req
);
  import wica_pkg::*;

  logic                       last_inflight_r, last_inflight_nxt;

  logic                       s2_valid_r;
  op_kind_t                   s2_kind_r;
  logic                       s2_last_r;
  logic [WPROD_W-1:0]         s2_wprod_r;
  logic signed [VALUE_W-1:0]  s2_value_r;

  logic                       s3_valid_r;
  op_kind_t                   s3_kind_r;
  logic                       s3_last_r;
  logic [WPROD_W-1:0]         s3_wprod_r;
  logic signed [VPROD_W-1:0]  s3_vprod_r;

  logic signed [VSUM_W-1:0]   vsum_r, vsum_nxt;
  logic [WSUM_W-1:0]          wsum_r, wsum_nxt;
  logic                       flag_r, flag_nxt;

  logic [WPROD_W-1:0]         wprod;
  logic signed [VPROD_W-1:0]  vprod;
  logic signed [VADD_W-1:0]   vs_add;
  logic [WADD_W-1:0]          ws_add;
  logic signed [VSUM_W-1:0]   acc_vsum;
  logic [WSUM_W-1:0]          acc_wsum;
  logic                       acc_flag;

  // Take an operation unless a query end is in flight or the divider is busy.
  assign pop = !q_empty && !last_inflight_r && !div_busy;

  // Overlap times weight, then times value.
  assign wprod = WPROD_W'(head.overlap) * WPROD_W'(head.weight);
  assign vprod = VPROD_W'($signed({1'b0, s2_wprod_r})) * VPROD_W'(s2_value_r);

  always_ff @(posedge clk) begin
    s2_kind_r  <= head.kind;
    s2_last_r  <= head.last;
    s2_wprod_r <= wprod;
    s2_value_r <= head.value;
    s3_kind_r  <= s2_kind_r;
    s3_last_r  <= s2_last_r;
    s3_wprod_r <= s2_wprod_r;
    s3_vprod_r <= vprod;
  end

  // Saturating sums.
  assign vs_add = $signed({vsum_r[VSUM_W-1], vsum_r}) + VADD_W'(s3_vprod_r);
  assign ws_add = {1'b0, wsum_r} + WADD_W'(s3_wprod_r);

  always_comb begin
    acc_vsum = vsum_r;
    acc_wsum = wsum_r;
    acc_flag = flag_r;
    if (s3_valid_r) begin
      unique case (s3_kind_r)
        OP_START: begin
          acc_vsum = '0;
          acc_wsum = '0;
          acc_flag = 1'b0;
        end
        OP_CELL: begin
          if (vs_add[VADD_W-1] != vs_add[VADD_W-2]) begin
            acc_vsum = vs_add[VADD_W-1] ? VSUM_MIN : VSUM_MAX;
            acc_flag = 1'b1;
          end else begin
            acc_vsum = VSUM_W'(vs_add);
          end
          if (ws_add[WADD_W-1]) begin
            acc_wsum = WSUM_MAX;
            acc_flag = 1'b1;
          end else begin
            acc_wsum = WSUM_W'(ws_add);
          end
        end
        OP_DROP: begin
          acc_flag = 1'b1;
        end
        default: begin
          acc_flag = flag_r;
        end
      endcase
    end
  end

  // A query end passes the sums on and clears them.
  always_comb begin
    div_req.valid = s3_valid_r && s3_last_r;
    div_req.flag  = acc_flag;
    div_req.vsum  = acc_vsum;
    div_req.wsum  = acc_wsum;
    vsum_nxt      = acc_vsum;
    wsum_nxt      = acc_wsum;
    flag_nxt      = acc_flag;
    if (s3_valid_r && s3_last_r) begin
      vsum_nxt = '0;
      wsum_nxt = '0;
      flag_nxt = 1'b0;
    end
  end

  // Track a query end between the queue and the divider.
  always_comb begin
    last_inflight_nxt = last_inflight_r;
    if (pop && head.last) begin
      last_inflight_nxt = 1'b1;
    end else if (s3_valid_r && s3_last_r) begin
      last_inflight_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r      <= 1'b0;
      s3_valid_r      <= 1'b0;
      last_inflight_r <= 1'b0;
      vsum_r          <= '0;
      wsum_r          <= '0;
      flag_r          <= 1'b0;
    end else begin
      s2_valid_r      <= pop;
      s3_valid_r      <= s2_valid_r;
      last_inflight_r <= last_inflight_nxt;
      vsum_r          <= vsum_nxt;
      wsum_r          <= wsum_nxt;
      flag_r          <= flag_nxt;
    end
  end

endmodule

### rtl/wica_div.sv
// ----------------------------------------------------------------------------
// wica_div
// Restoring divider, one quotient bit a cycle, with clamping of the average
// and the result output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wica_div (
  input  logic               clk,
  input  logic               rst_n,
  input  wica_pkg::div_req_t div_req,
  output logic               busy,
  wica_out_if.source         out_ch
);
  import wica_pkg::*;

  typedef enum logic [3:0] {
    DS_IDLE = 4'b0001,
    DS_PREP = 4'b0010,
    DS_RUN  = 4'b0100,
    DS_DONE = 4'b1000
  } div_state_t;

  localparam logic [QUOT_W-2:0] QPOS_LIM = (QUOT_W-1)'(2 ** (AVG_W - 1) - 1);
  localparam logic [QUOT_W-2:0] QNEG_LIM = (QUOT_W-1)'(2 ** (AVG_W - 1));

  div_state_t               state_r, state_nxt;
  logic signed [VSUM_W-1:0] vsum_r, vsum_nxt;
  logic [WSUM_W-1:0]        wsum_r, wsum_nxt;
  logic                     flag_r, flag_nxt;
  logic                     neg_r, neg_nxt;
  logic                     zero_r, zero_nxt;
  logic [VSUM_W-1:0]        rem_r, rem_nxt;
  logic [DEN_W-1:0]         den_r, den_nxt;
  logic [QUOT_W-1:0]        q_r, q_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;

  logic                     ovalid_r, ovalid_nxt;
  logic signed [AVG_W-1:0]  avg_r, avg_nxt;
  logic                     zw_r, zw_nxt;
  logic                     sat_r, sat_nxt;

  logic                     ge;
  logic                     out_free;
  logic [QUOT_W-2:0]        qmag;
  logic                     qbig;
  logic signed [AVG_W-1:0]  avg_fin;
  logic                     sat_fin;

  assign busy     = (state_r != DS_IDLE);
  assign out_free = !ovalid_r || out_ch.ready;
  assign ge       = (DEN_W'(rem_r) >= den_r);

  assign out_ch.valid       = ovalid_r;
  assign out_ch.average     = avg_r;
  assign out_ch.zero_weight = zw_r;
  assign out_ch.saturated   = sat_r;

  // Sign, clamp and zero-weight handling of the final quotient.
  always_comb begin
    qmag    = q_r[QUOT_W-2:0];
    qbig    = q_r[QUOT_W-1];
    sat_fin = flag_r;
    if (zero_r) begin
      avg_fin = '0;
    end else if (!neg_r) begin
      if (qbig || (qmag > QPOS_LIM)) begin
        avg_fin = {1'b0, {(AVG_W-1){1'b1}}};
        sat_fin = 1'b1;
      end else begin
        avg_fin = AVG_W'(qmag);
      end
    end else begin
      if (qbig || (qmag > QNEG_LIM)) begin
        avg_fin = {1'b1, {(AVG_W-1){1'b0}}};
        sat_fin = 1'b1;
      end else begin
        avg_fin = AVG_W'(~qmag + 1'b1);
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    vsum_nxt   = vsum_r;
    wsum_nxt   = wsum_r;
    flag_nxt   = flag_r;
    neg_nxt    = neg_r;
    zero_nxt   = zero_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    q_nxt      = q_r;
    step_nxt   = step_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    avg_nxt    = avg_r;
    zw_nxt     = zw_r;
    sat_nxt    = sat_r;
    unique case (state_r)
      DS_IDLE: begin
        if (div_req.valid) begin
          vsum_nxt  = div_req.vsum;
          wsum_nxt  = div_req.wsum;
          flag_nxt  = div_req.flag;
          state_nxt = DS_PREP;
        end
      end
      DS_PREP: begin
        neg_nxt  = vsum_r[VSUM_W-1];
        zero_nxt = (wsum_r == '0);
        rem_nxt  = vsum_r[VSUM_W-1] ? VSUM_W'(~vsum_r + 1'b1) : VSUM_W'(vsum_r);
        den_nxt  = {wsum_r, {(QUOT_W-1){1'b0}}};
        q_nxt    = '0;
        step_nxt = STEP_W'(QUOT_W - 1);
        state_nxt = (wsum_r == '0) ? DS_DONE : DS_RUN;
      end
      DS_RUN: begin
        if (ge) begin
          rem_nxt = rem_r - den_r[VSUM_W-1:0];
        end
        q_nxt    = {q_r[QUOT_W-2:0], ge};
        den_nxt  = den_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = DS_DONE;
        end
      end
      DS_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          avg_nxt    = avg_fin;
          zw_nxt     = zero_r;
          sat_nxt    = sat_fin;
          state_nxt  = DS_IDLE;
        end
      end
      default: begin
        state_nxt = DS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= DS_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vsum_r <= vsum_nxt;
    wsum_r <= wsum_nxt;
    flag_r <= flag_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    avg_r  <= avg_nxt;
    zw_r   <= zw_nxt;
    sat_r  <= sat_nxt;
  end

  `ASSERT_IMP(a_req_when_idle, div_req.valid, state_r == DS_IDLE,
              "sums handed over while the divider is busy")
  `ASSERT_IMP(a_step_range, state_r == DS_RUN, step_r <= STEP_W'(QUOT_W - 1),
              "divider step count out of range")
  `ASSERT_IMP(a_zero_avg, ovalid_r && zw_r, avg_r == '0,
              "zero weight result with a nonzero average")

endmodule

### dv/wica_avg_checker.sv
// ----------------------------------------------------------------------------
// wica_avg_checker
// Watches the cell and result channels of the weighted interval cell average.
// It keeps its own copy of the interval, the running sums and the cell count,
// works out the average that each last cell must give, and compares every
// result beat field by field with the oldest average still due.
// ----------------------------------------------------------------------------
module wica_avg_checker #(
  parameter int MAX_CELLS = wica_pkg::MAX_CELLS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  wica_in_if   in_mon,
  wica_out_if  out_mon,
  output int   fail_count,
  output int   pending
);
  import wica_pkg::*;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic                    zero_weight;
    logic                    saturated;
  } average_beat_t;

  localparam longint VALUE_CAP_HI  = longint'(VSUM_MAX);
  localparam longint VALUE_CAP_LO  = longint'(VSUM_MIN);
  localparam longint WEIGHT_CAP    = longint'(WSUM_MAX);
  localparam longint AVERAGE_HI    = 32767;
  localparam longint AVERAGE_LO    = -32768;

  // Query state as the block should hold it.
  logic signed [COORD_BITS-1:0] span_lo;
  logic signed [COORD_BITS-1:0] span_hi;
  longint                       value_acc;
  longint                       weight_acc;
  int                           cells_taken;
  bit                           sums_clipped;

  average_beat_t averages_due[$];
  int            mismatches;

  task automatic clear_query();
    value_acc    = 0;
    weight_acc   = 0;
    cells_taken  = 0;
    sums_clipped = 1'b0;
  endtask

  // Fold one accepted cell or start beat into the query state and queue the
  // average that a last cell closes.
  task automatic fold_beat(
    input logic                         kind,
    input logic signed [COORD_BITS-1:0] q_lo,
    input logic signed [COORD_BITS-1:0] q_hi,
    input logic signed [COORD_BITS-1:0] f_lo,
    input logic signed [COORD_BITS-1:0] f_hi,
    input logic signed [VALUE_W-1:0]    value,
    input logic [WEIGHT_W-1:0]          weight,
    input logic                         last
  );
    longint        lo;
    longint        hi;
    longint        overlap;
    longint        wprod;
    longint        vsum;
    longint        quotient;
    average_beat_t due;

    if (op_kind_t'({1'b0, kind}) == OP_START) begin
      span_lo = q_lo;
      span_hi = q_hi;
      clear_query();
      return;
    end

    // A cell past the limit is dropped but still marks the result.
    if (cells_taken >= MAX_CELLS) begin
      sums_clipped = 1'b1;
    end else begin
      cells_taken++;
      lo = f_lo;
      hi = f_hi;
      if (lo < span_lo) lo = span_lo;
      if (hi > span_hi) hi = span_hi;
      overlap = (hi > lo) ? (hi - lo) : 0;
      wprod = overlap * longint'(weight);
      if (wprod != 0) begin
        weight_acc += wprod;
        if (weight_acc > WEIGHT_CAP) begin
          weight_acc   = WEIGHT_CAP;
          sums_clipped = 1'b1;
        end
        vsum = value_acc + wprod * longint'(value);
        if (vsum > VALUE_CAP_HI) begin
          vsum         = VALUE_CAP_HI;
          sums_clipped = 1'b1;
        end else if (vsum < VALUE_CAP_LO) begin
          vsum         = VALUE_CAP_LO;
          sums_clipped = 1'b1;
        end
        value_acc = vsum;
      end
    end

    if (!last) return;

    // Close the query: divide with truncation toward zero, clamp to Q8.8.
    due.saturated = sums_clipped;
    if (weight_acc == 0) begin
      quotient        = 0;
      due.zero_weight = 1'b1;
    end else begin
      quotient = value_acc / weight_acc;
      if (quotient > AVERAGE_HI) begin
        quotient      = AVERAGE_HI;
        due.saturated = 1'b1;
      end else if (quotient < AVERAGE_LO) begin
        quotient      = AVERAGE_LO;
        due.saturated = 1'b1;
      end
      due.zero_weight = 1'b0;
    end
    due.average = quotient[AVG_W-1:0];
    averages_due.push_back(due);
    clear_query();
  endtask

  // Sample both channels on the rising edge.
  always @(posedge clk) begin
    average_beat_t due;

    if (!rst_n) begin
      span_lo = '0;
      span_hi = '0;
      clear_query();
      averages_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        fold_beat(in_mon.kind, in_mon.query_low, in_mon.query_high, in_mon.face_left,
                  in_mon.face_right, in_mon.cell_value, in_mon.cell_weight,
                  in_mon.last_cell);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (averages_due.size() == 0) begin
          $display("%0t: result beat with no average due: average %0d zero_weight %0b saturated %0b",
                   $time, out_mon.average, out_mon.zero_weight, out_mon.saturated);
          mismatches++;
        end else begin
          due = averages_due.pop_front();
          if (out_mon.average !== due.average) begin
            $display("%0t: average mismatch: expected %0d, actual %0d",
                     $time, due.average, out_mon.average);
            mismatches++;
          end
          if (out_mon.zero_weight !== due.zero_weight) begin
            $display("%0t: zero_weight mismatch: expected %0b, actual %0b",
                     $time, due.zero_weight, out_mon.zero_weight);
            mismatches++;
          end
          if (out_mon.saturated !== due.saturated) begin
            $display("%0t: saturated mismatch: expected %0b, actual %0b",
                     $time, due.saturated, out_mon.saturated);
            mismatches++;
          end
        end
      end
    end
    pending    <= averages_due.size();
    fail_count <= mismatches;
  end

endmodule

### dv/weighted_interval_cell_average_tb.sv
// ----------------------------------------------------------------------------
// weighted_interval_cell_average_tb
// Drives query start and cell beats into the weighted interval cell average,
// with random gaps on the sender and random stalls on the receiver. A short
// directed run covers the field extremes and the corner cases; random queries
// follow, mostly grids that walk across the interval, plus noise, aborted
// queries and one query that runs past the cell limit. The checker beside the
// block predicts every result; this module only gives the verdict.
// ----------------------------------------------------------------------------
module weighted_interval_cell_average_tb;
  import wica_pkg::*;

  localparam int MAX_CELLS      = MAX_CELLS_DEF;
  localparam int BEAT_TARGET    = 1600;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int COORD_LO       = -(1 << (COORD_BITS - 1));
  localparam int COORD_HI       = (1 << (COORD_BITS - 1)) - 1;
  localparam int VALUE_LO       = -32768;
  localparam int VALUE_HI       = 32767;
  localparam int WEIGHT_HI      = (1 << WEIGHT_W) - 1;

  localparam logic BEAT_START = 1'(OP_START);
  localparam logic BEAT_CELL  = 1'(OP_CELL);

  logic clk;
  logic rst_n;

  wica_in_if  in_ch ();
  wica_out_if out_ch ();

  int fail_count;
  int pending;
  int beats_sent;
  int idle_cycles;
  bit calm_sender;
  bit hold_req;

  weighted_interval_cell_average #(
    .MAX_CELLS(MAX_CELLS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  wica_avg_checker #(
    .MAX_CELLS(MAX_CELLS)
  ) u_avg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_coord(input longint x);
    if (x < COORD_LO) return COORD_LO;
    if (x > COORD_HI) return COORD_HI;
    return int'(x);
  endfunction

  function automatic int rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return int'($urandom_range(0, 16777215)) + COORD_LO;
    if (r < 3) return $urandom_range(0, 1) ? COORD_HI : COORD_LO;
    return int'($urandom_range(0, 131071)) - 65536;
  endfunction

  function automatic int rand_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return VALUE_LO;
    if (r == 1) return VALUE_HI;
    return int'($urandom_range(0, 65535)) + VALUE_LO;
  endfunction

  function automatic int rand_weight();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return WEIGHT_HI;
    return $urandom_range(1, WEIGHT_HI - 1);
  endfunction

  // Offer one beat from a falling edge and wait until it is taken. Fields the
  // beat does not use carry random bits.
  task automatic send_beat(input logic kind, input int a, input int b, input int value,
                           input int weight, input bit last);
    int gap;
    gap = calm_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    if (kind == BEAT_START) begin
      in_ch.query_low   <= a[COORD_BITS-1:0];
      in_ch.query_high  <= b[COORD_BITS-1:0];
      in_ch.face_left   <= COORD_BITS'($urandom);
      in_ch.face_right  <= COORD_BITS'($urandom);
      in_ch.cell_value  <= VALUE_W'($urandom);
      in_ch.cell_weight <= WEIGHT_W'($urandom);
    end else begin
      in_ch.query_low   <= COORD_BITS'($urandom);
      in_ch.query_high  <= COORD_BITS'($urandom);
      in_ch.face_left   <= a[COORD_BITS-1:0];
      in_ch.face_right  <= b[COORD_BITS-1:0];
      in_ch.cell_value  <= value[VALUE_W-1:0];
      in_ch.cell_weight <= weight[WEIGHT_W-1:0];
    end
    in_ch.last_cell <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic start_query(input int lo, input int hi);
    send_beat(BEAT_START, lo, hi, 0, 0, $urandom_range(0, 1));
  endtask

  task automatic send_cell(input int f_lo, input int f_hi, input int value, input int weight,
                           input bit last);
    send_beat(BEAT_CELL, f_lo, f_hi, value, weight, last);
  endtask

  // A grid of adjacent cells that walks across the interval from just left of
  // it; a few intervals are given with their bounds reversed.
  task automatic grid_query(input int n_cells);
    int     lo;
    int     hi;
    int     span;
    int     step;
    int     width;
    longint pos;
    lo   = rand_coord();
    span = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16777215)
                                       : $urandom_range(1, 40000);
    hi   = clamp_coord(longint'(lo) + span);
    if ($urandom_range(0, 19) == 0) start_query(hi, lo);
    else start_query(lo, hi);
    step = span / n_cells + 1;
    pos  = longint'(lo) - $urandom_range(0, step);
    for (int i = 0; i < n_cells; i++) begin
      width = $urandom_range(0, 2 * step);
      send_cell(clamp_coord(pos), clamp_coord(pos + width), rand_value(), rand_weight(),
                i == n_cells - 1);
      pos += width;
    end
  endtask

  // Cells with unrelated faces, reversed ones among them.
  task automatic noise_cells(input int n_cells, input bit close);
    for (int i = 0; i < n_cells; i++) begin
      send_cell(rand_coord(), rand_coord(), rand_value(), rand_weight(),
                close && (i == n_cells - 1));
    end
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin
    int  stall_left;
    int  calm_left;
    bit  hold_served;
    stall_left  = 0;
    calm_left   = 0;
    hold_served = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served = 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          stall_left = pick_gap();
          if ($urandom_range(0, 199) == 0) calm_left = 60;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    bit long_done;
    int r;
    int n;

    rst_n             = 1'b0;
    calm_sender       = 1'b0;
    hold_req          = 1'b0;
    beats_sent        = 0;
    long_done         = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = BEAT_START;
    in_ch.query_low   = '0;
    in_ch.query_high  = '0;
    in_ch.face_left   = '0;
    in_ch.face_right  = '0;
    in_ch.cell_value  = '0;
    in_ch.cell_weight = '0;
    in_ch.last_cell   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A cell before any start sees the empty reset interval.
    send_cell(-100, 100, 256, 16, 1'b1);
    // A start beat never emits, even with its last flag set.
    send_beat(BEAT_START, COORD_LO, COORD_HI, 0, 0, 1'b1);
    // Widest cells at both value extremes and full weight, then a reversed
    // cell and a zero-weight last cell.
    send_cell(COORD_LO, COORD_HI, VALUE_HI, WEIGHT_HI, 1'b0);
    send_cell(COORD_LO, COORD_HI, VALUE_LO, WEIGHT_HI, 1'b0);
    send_cell(4096, -4096, 1000, 100, 1'b0);
    send_cell(-4096, 4096, 5, 0, 1'b1);
    // Reversed bounds: nothing overlaps.
    send_beat(BEAT_START, 20480, -20480, 0, 0, 1'b0);
    send_cell(-8192, 8192, 300, 200, 1'b1);
    // Interval [0, 4.0]: cells fully left, fully right, straddling, inside,
    // and one of zero width on the right bound.
    send_beat(BEAT_START, 0, 16384, 0, 0, 1'b0);
    send_cell(-8192, -4096, 100, 256, 1'b0);
    send_cell(20480, 24576, 100, 256, 1'b0);
    send_cell(-2048, 2048, 384, 256, 1'b0);
    send_cell(4096, 8192, -512, WEIGHT_HI, 1'b0);
    send_cell(16384, 16384, 77, WEIGHT_HI, 1'b1);
    // A small negative average truncates toward zero.
    send_beat(BEAT_START, 0, 4096, 0, 0, 1'b0);
    send_cell(0, 4096, -1, 1, 1'b0);
    send_cell(0, 4096, 0, 2, 1'b1);
    // The interval is kept after a result.
    send_cell(-4096, 8192, VALUE_LO, 1, 1'b1);
    // A new start drops an open query.
    send_beat(BEAT_START, -4096, 4096, 0, 0, 1'b0);
    send_cell(-4096, 4096, VALUE_HI, WEIGHT_HI, 1'b0);
    send_beat(BEAT_START, -8192, 8192, 0, 0, 1'b0);
    send_cell(-8192, 0, -200, 9, 1'b1);

    // The receiver holds off while short queries keep coming, so the
    // results back up and the input stalls.
    hold_req    = 1'b1;
    calm_sender = 1'b1;
    for (int i = 0; i < 24; i++) grid_query($urandom_range(1, 2));

    // Random queries.
    while (beats_sent < BEAT_TARGET) begin
      calm_sender = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (!long_done && beats_sent > 300) begin
        // One query that runs past the cell limit.
        calm_sender = 1'b1;
        start_query(COORD_LO, COORD_HI);
        noise_cells(MAX_CELLS + 2, 1'b1);
        long_done = 1'b1;
      end else if (r < 70) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        grid_query(n);
      end else if (r < 82) begin
        start_query(rand_coord(), rand_coord());
        noise_cells($urandom_range(1, 6), 1'b1);
      end else if (r < 90) begin
        // Aborted query: no last cell before the next start.
        start_query(rand_coord(), rand_coord());
        noise_cells($urandom_range(1, 4), 1'b0);
      end else begin
        // Stray cells on the kept interval.
        noise_cells($urandom_range(1, 3), 1'b1);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
